/* sv/software_timer_queue_core_defines.svh */
// Assertion macros for the software timer queue checker.
`ifndef SOFTWARE_TIMER_QUEUE_CORE_DEFINES_SVH
`define SOFTWARE_TIMER_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define STQ_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/stq_pkg.sv */
// Shared types and constants for the software timer queue.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

   localparam int TIMERS  = 16;
   localparam int MAX_OUT = 16;
   localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CNT_W   = $clog2(MAX_OUT + 1);

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_SERVICE = 2'd2,
      KIND_QUERY   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_ADDED        = 3'd0,
      STAT_REMOVED      = 3'd1,
      STAT_NOT_FOUND    = 3'd2,
      STAT_FULL         = 3'd3,
      STAT_EXPIRED      = 3'd4,
      STAT_NONE_EXPIRED = 3'd5,
      STAT_REMAINING    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_FLUSH
   } state_type;

   // One slot as seen by the scan comparator.
   typedef struct packed {
      logic        valid;
      logic        done;
      logic [31:0] id;
      logic [31:0] deadline;
   } slot_view_type;

   // Best candidate found so far in the current scan.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [31:0]      id;
      logic [31:0]      deadline;
      logic [31:0]      period;
      logic             rpt;
   } best_type;

endpackage

`default_nettype wire

/* sv/stq_if.sv */
// Request and response channel interfaces for the software timer queue.
`timescale 1ns / 1ps
`default_nettype none

interface stq_req_if;
   import stq_pkg::*;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [31:0] now_ms;
   logic [31:0] interval_ms;
   logic        repeat_req;
   logic [31:0] target_id;

   modport source (output valid, output kind, output now_ms, output interval_ms,
                   output repeat_req, output target_id, input ready);
   modport sink   (input valid, input kind, input now_ms, input interval_ms,
                   input repeat_req, input target_id, output ready);
endinterface

interface stq_rsp_if;
   import stq_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [31:0]        timer_num;
   logic signed [32:0] remaining_ms;
   logic               last;

   modport source (output valid, output status, output timer_num, output remaining_ms,
                   output last, input ready);
   modport sink   (input valid, input status, input timer_num, input remaining_ms,
                   input last, output ready);
endinterface

`default_nettype wire

/* sv/stq_scan_unit.sv */
// Shared slot comparator: decides whether the scanned slot becomes the new candidate.
`timescale 1ns / 1ps
`default_nettype none

module stq_scan_unit (
   input  stq_pkg::kind_type      kind,
   input  logic [31:0]            now_ms,
   input  logic [31:0]            target_id,
   input  stq_pkg::slot_view_type slot,
   input  stq_pkg::best_type      best,
   output logic                   take
);
   import stq_pkg::*;

   logic dl_less;
   logic dl_equal;
   logic id_less;
   logic expired;

   assign dl_less  = slot.deadline < best.deadline;
   assign dl_equal = slot.deadline == best.deadline;
   assign id_less  = slot.id < best.id;
   assign expired  = slot.deadline <= now_ms;

   always_comb begin
      unique case (kind)
         KIND_ADD: begin
            // first free slot wins
            take = !slot.valid && !best.found;
         end
         KIND_REMOVE: begin
            take = slot.valid && (slot.id == target_id) && !best.found;
         end
         KIND_QUERY: begin
            take = slot.valid && (!best.found || dl_less);
         end
         KIND_SERVICE: begin
            // order by (deadline, id); strict compare keeps the lower slot on ties
            take = slot.valid && !slot.done && expired &&
                   (!best.found || dl_less || (dl_equal && id_less));
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/software_timer_queue_core.sv */
// Top level of the software timer queue: slot table, scan sequencer and response register.
// Add, remove and query: accept, a scan of all TIMERS slots (one comparator), then finish.
// Service: accept, then a scan and a finish per expired timer, then a final scan and finish
// (or a flush after the sixteenth timer); finish and flush wait while the output is stalled.
// A result may wait in the output register while the next request is accepted.
// Synchronous reset empties the table, zeroes the id counter and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_queue_core (
   input  logic      clock,
   input  logic      reset,
   stq_req_if.sink   req_chan,
   stq_rsp_if.source rsp_chan
);
   import stq_pkg::*;

   state_type          state_ff, state_in;

   kind_type           kind_ff;
   logic [31:0]        now_ff;
   logic [31:0]        ival_ff;
   logic               rep_ff;
   logic [31:0]        target_ff;

   logic [TIMERS-1:0]  valid_ff;
   logic [TIMERS-1:0]  done_ff;
   logic [31:0]        slot_id_ff  [TIMERS];
   logic [31:0]        slot_dl_ff  [TIMERS];
   logic [31:0]        slot_per_ff [TIMERS];
   logic [TIMERS-1:0]  slot_rep_ff;

   logic [IDX_W-1:0]   scan_idx_ff;
   best_type           best_ff;
   logic               pend_ff;
   logic [31:0]        pend_id_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [31:0]        next_id_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [31:0]        rsp_id_ff;
   logic signed [32:0] rsp_rem_ff;
   logic               rsp_last_ff;

   slot_view_type      slot_view;
   logic               take;
   logic               scan_last;
   logic               out_free;
   logic               do_accept;
   logic               do_scan;
   logic               do_finish;
   logic               do_flush;
   logic               svc_hit;
   logic               cnt_full;

   logic [31:0]        add_b;
   logic [32:0]        sum;
   logic [31:0]        sat_sum;
   logic [31:0]        diff;

   logic               load_rsp;
   status_type         nx_status;
   logic [31:0]        nx_id;
   logic signed [32:0] nx_rem;
   logic               nx_last;

   // scanned slot
   always_comb begin
      slot_view.valid    = valid_ff[scan_idx_ff];
      slot_view.done     = done_ff[scan_idx_ff];
      slot_view.id       = slot_id_ff[scan_idx_ff];
      slot_view.deadline = slot_dl_ff[scan_idx_ff];
   end

   stq_scan_unit u_scan (
      .kind      (kind_ff),
      .now_ms    (now_ff),
      .target_id (target_ff),
      .slot      (slot_view),
      .best      (best_ff),
      .take      (take)
   );

   assign scan_last = scan_idx_ff == IDX_W'(TIMERS - 1);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign svc_hit   = (kind_ff == KIND_SERVICE) && best_ff.found;
   assign cnt_full  = cnt_ff == CNT_W'(MAX_OUT - 1);

   // shared saturating adder: new deadline on add, rearm on service
   assign add_b   = (kind_ff == KIND_ADD) ? ival_ff : best_ff.period;
   assign sum     = {1'b0, now_ff} + {1'b0, add_b};
   assign sat_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign diff    = best_ff.deadline - now_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               if (svc_hit) state_in = cnt_full ? S_FLUSH : S_SCAN;
               else         state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      do_accept = 1'b0;
      do_scan   = 1'b0;
      do_finish = 1'b0;
      do_flush  = 1'b0;
      unique case (state_ff)
         S_IDLE:   do_accept = req_chan.valid;
         S_SCAN:   do_scan   = 1'b1;
         S_FINISH: do_finish = out_free;
         S_FLUSH:  do_flush  = out_free;
         default:  do_accept = 1'b0;
      endcase
   end

   assign req_chan.ready = state_ff == S_IDLE;

   // response word
   always_comb begin
      load_rsp  = 1'b0;
      nx_status = STAT_NONE_EXPIRED;
      nx_id     = 32'd0;
      nx_rem    = 33'sd0;
      nx_last   = 1'b1;
      if (do_finish) begin
         unique case (kind_ff)
            KIND_ADD: begin
               load_rsp = 1'b1;
               if (best_ff.found) begin
                  nx_status = STAT_ADDED;
                  nx_id     = next_id_ff + 32'd1;
               end else begin
                  nx_status = STAT_FULL;
               end
            end
            KIND_REMOVE: begin
               load_rsp  = 1'b1;
               nx_status = best_ff.found ? STAT_REMOVED : STAT_NOT_FOUND;
            end
            KIND_QUERY: begin
               load_rsp  = 1'b1;
               nx_status = STAT_REMAINING;
               if (!best_ff.found)                nx_rem = -33'sd1;
               else if (best_ff.deadline > now_ff) nx_rem = $signed({1'b0, diff});
               else                               nx_rem = 33'sd0;
            end
            KIND_SERVICE: begin
               // emit the held timer only once the next scan shows whether it is final
               if (best_ff.found) begin
                  load_rsp  = pend_ff;
                  nx_status = STAT_EXPIRED;
                  nx_id     = pend_id_ff;
                  nx_last   = 1'b0;
               end else begin
                  load_rsp = 1'b1;
                  if (pend_ff) begin
                     nx_status = STAT_EXPIRED;
                     nx_id     = pend_id_ff;
                  end
               end
            end
            default: begin
               load_rsp = 1'b0;
            end
         endcase
      end else if (do_flush) begin
         load_rsp  = 1'b1;
         nx_status = STAT_EXPIRED;
         nx_id     = pend_id_ff;
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         next_id_ff   <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_finish && best_ff.found) begin
            unique case (kind_ff)
               KIND_ADD: begin
                  valid_ff[best_ff.idx] <= 1'b1;
                  next_id_ff            <= next_id_ff + 32'd1;
               end
               KIND_REMOVE: begin
                  valid_ff[best_ff.idx] <= 1'b0;
               end
               KIND_SERVICE: begin
                  // free a one-shot timer
                  if (!best_ff.rpt) valid_ff[best_ff.idx] <= 1'b0;
               end
               KIND_QUERY: begin
                  valid_ff <= valid_ff;
               end
               default: begin
                  valid_ff <= valid_ff;
               end
            endcase
         end
      end
   end

   // request, scan and slot payload
   always_ff @(posedge clock) begin
      if (do_accept) begin
         kind_ff       <= req_chan.kind;
         now_ff        <= req_chan.now_ms;
         ival_ff       <= req_chan.interval_ms;
         rep_ff        <= req_chan.repeat_req;
         target_ff     <= req_chan.target_id;
         scan_idx_ff   <= '0;
         best_ff.found <= 1'b0;
         done_ff       <= '0;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
      end
      if (do_scan) begin
         scan_idx_ff <= scan_last ? '0 : scan_idx_ff + IDX_W'(1);
         if (take) begin
            best_ff.found    <= 1'b1;
            best_ff.idx      <= scan_idx_ff;
            best_ff.id       <= slot_id_ff[scan_idx_ff];
            best_ff.deadline <= slot_dl_ff[scan_idx_ff];
            best_ff.period   <= slot_per_ff[scan_idx_ff];
            best_ff.rpt      <= slot_rep_ff[scan_idx_ff];
         end
      end
      if (do_finish && best_ff.found) begin
         if (kind_ff == KIND_ADD) begin
            slot_id_ff[best_ff.idx]  <= next_id_ff + 32'd1;
            slot_dl_ff[best_ff.idx]  <= sat_sum;
            slot_per_ff[best_ff.idx] <= (ival_ff == 32'd0) ? 32'd1 : ival_ff;
            slot_rep_ff[best_ff.idx] <= rep_ff;
         end
         if (kind_ff == KIND_SERVICE) begin
            done_ff[best_ff.idx] <= 1'b1;
            if (best_ff.rpt) slot_dl_ff[best_ff.idx] <= sat_sum;
            pend_ff       <= 1'b1;
            pend_id_ff    <= best_ff.id;
            cnt_ff        <= cnt_ff + CNT_W'(1);
            best_ff.found <= 1'b0;
         end
      end
      if (load_rsp) begin
         rsp_status_ff <= nx_status;
         rsp_id_ff     <= nx_id;
         rsp_rem_ff    <= nx_rem;
         rsp_last_ff   <= nx_last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.timer_num    = rsp_id_ff;
   assign rsp_chan.remaining_ms = rsp_rem_ff;
   assign rsp_chan.last         = rsp_last_ff;

endmodule

`default_nettype wire

/* sv/stq_checker.sv */
// Port-level checker for the software timer queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "software_timer_queue_core_defines.svh"

module stq_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire stq_pkg::status_type rsp_status,
   input wire logic [31:0]        rsp_timer_num,
   input wire logic signed [32:0] rsp_remaining,
   input wire logic               rsp_last
);
   import stq_pkg::*;

   logic        stall;
   logic        accepted;
   logic        single;
   logic        single_ok;
   logic [69:0] word;

   assign stall     = rsp_valid && !rsp_ready;
   assign accepted  = req_valid && req_ready;
   assign single    = rsp_valid && (rsp_status != STAT_EXPIRED);
   assign single_ok = rsp_last &&
                      ((rsp_status == STAT_REMAINING) || (rsp_remaining == 33'sd0));
   assign word      = {rsp_valid, rsp_status, rsp_timer_num, rsp_remaining, rsp_last};

   // a stalled word holds
   `STQ_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, $stable(word), "stalled word changed")

   // only service produces more than one word per request
   `STQ_ASSERT_NOW(a_single_last, clock, reset, single, single_ok, "bad single word")

   // busy while a request is being worked on
   `STQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, accepted, !req_ready, "ready after accept")

   // reset drops any pending response
   `STQ_ASSERT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "response valid after reset")

endmodule

bind software_timer_queue_core stq_checker u_stq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_timer_num (rsp_chan.timer_num),
   .rsp_remaining (rsp_chan.remaining_ms),
   .rsp_last      (rsp_chan.last)
);

`default_nettype wire
